// File: src/iidl_pkg.sv
// Shared constants, codes and types for the indexed insert/delete list unit.
package iidl_pkg;

  localparam int CAPACITY      = 32;
  localparam int DATA_BITS     = 32;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 16;
  localparam int OUT_CNT_W     = 6;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int REM_BITS_STEP = 2;
  localparam int REM_STEPS     = POS_W / REM_BITS_STEP;
  localparam int REM_STEP_W    = $clog2(REM_STEPS);

  typedef logic [DATA_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOD,
    S_EDIT,
    S_RESP,
    S_DUMP
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rot;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] tail;
  } cell_ctl_t;

endpackage

// File: src/iidl_cell.sv
// One storage cell of the list chain: holds a word, shifts to or from its neighbors.
module iidl_cell import iidl_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [IDX_W-1:0] slot_i,
  input  word_t            prev_i,
  input  word_t            next_i,
  input  word_t            head_i,
  input  word_t            new_i,
  output word_t            word_o
);

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (slot_i > ctl_i.idx) begin
        word_d = prev_i;
      end else if (slot_i == ctl_i.idx) begin
        word_d = new_i;
      end
    end else if (ctl_i.del) begin
      if (slot_i >= ctl_i.idx) begin
        word_d = next_i;
      end
    end else if (ctl_i.rot) begin
      // rotate live entries left; head wraps into the tail slot
      if (slot_i < ctl_i.tail) begin
        word_d = next_i;
      end else if (slot_i == ctl_i.tail) begin
        word_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// File: src/iidl_rem.sv
// Iterative remainder unit: position modulo entry count, two bits per cycle.
module iidl_rem import iidl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [POS_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [REM_STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]      dvd_q, dvd_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W:0]        trial;
  logic [CNT_W-1:0]      r_work;
  logic [POS_W-1:0]      d_work;

  // restoring steps on a remainder that always stays below the divisor
  always_comb begin
    r_work = rem_q;
    d_work = dvd_q;
    trial  = '0;
    for (int k = 0; k < REM_BITS_STEP; k++) begin
      trial  = {r_work, d_work[POS_W-1]};
      d_work = {d_work[POS_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      r_work = trial[CNT_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d  = d_work;
      rem_d  = r_work;
      step_d = step_q + REM_STEP_W'(1);
      if (step_q == REM_STEP_W'(REM_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: src/indexed_insert_delete_list_unit.sv
// Indexed insert/delete list: control, cell chain and result register.
// Insert/delete at first or last: decode, edit and load of the result register.
// Positional insert/delete: a remainder step before the edit, 2 position bits a cycle.
// Dump: one entry a cycle while the output is not stalled, as the cell chain rotates past its head.
// Next request is taken once the previous one is finished; the result register decouples output.
// Reset clears the entry count, state and output valid; cell contents are undefined until written.
module indexed_insert_delete_list_unit import iidl_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  operation_i,
  input  logic signed [VALUE_W-1:0]   value_i,
  input  logic [POS_W-1:0]            position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [VALUE_W-1:0]   data_o,
  output logic                        last_o,
  output logic [1:0]                  status_o,
  output logic [OUT_CNT_W-1:0]        count_o
);

  state_e            state_q, state_d;
  logic [2:0]        op_q;
  word_t             val_q;
  logic [POS_W-1:0]  pos_q;
  logic [IDX_W-1:0]  idx_q;
  status_e           res_status_q;
  logic [IDX_W-1:0]  dump_idx_q;
  logic [CNT_W-1:0]  count_q;

  logic                      out_valid_q;
  logic [VALUE_W-1:0]        out_data_q, out_data_d;
  logic                      out_last_q, out_last_d;
  status_e                   out_status_q, out_status_d;
  logic [CNT_W-1:0]          out_count_q;

  logic             is_ins, is_del, is_dump, full, empty, need_mod;
  logic             out_free, out_load, rem_start, rem_done;
  logic [CNT_W-1:0] rem;
  logic [IDX_W-1:0] tail;
  cell_ctl_t        cell_ctl;
  word_t            words [CAPACITY];
  logic [63:0]      value_wide;
  logic [63:0]      head_wide;

  assign is_ins  = (op_q == OP_INS_FIRST) || (op_q == OP_INS_LAST) || (op_q == OP_INS_POS);
  assign is_del  = (op_q == OP_DEL_FIRST) || (op_q == OP_DEL_LAST) || (op_q == OP_DEL_POS);
  assign is_dump = (op_q == OP_DUMP);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign tail    = IDX_W'(count_q - CNT_W'(1));
  assign need_mod = !empty && ((op_q == OP_INS_POS && !full) || (op_q == OP_DEL_POS));
  assign out_free = !out_valid_q || !out_stall_i;

  assign value_wide = {32'd0, value_i};
  assign head_wide  = 64'(words[0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (is_ins) begin
          state_d = full ? S_RESP : (need_mod ? S_MOD : S_EDIT);
        end else if (is_del) begin
          state_d = empty ? S_RESP : (need_mod ? S_MOD : S_EDIT);
        end else if (is_dump) begin
          state_d = empty ? S_RESP : S_DUMP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          state_d = S_EDIT;
        end
      end
      S_EDIT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && dump_idx_q == tail) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o    = (state_q != S_IDLE);
    rem_start     = (state_q == S_DECODE) && need_mod;
    cell_ctl.ins  = (state_q == S_EDIT) && is_ins;
    cell_ctl.del  = (state_q == S_EDIT) && is_del;
    cell_ctl.rot  = (state_q == S_DUMP) && out_free;
    cell_ctl.idx  = idx_q;
    cell_ctl.tail = tail;
    out_load      = ((state_q == S_RESP) || (state_q == S_DUMP)) && out_free;
    out_data_d    = '0;
    out_last_d    = 1'b1;
    out_status_d  = res_status_q;
    if (state_q == S_DUMP) begin
      out_data_d   = head_wide[VALUE_W-1:0];
      out_last_d   = (dump_idx_q == tail);
      out_status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cell_ctl.ins) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cell_ctl.del) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= operation_i;
      val_q <= value_wide[DATA_BITS-1:0];
      pos_q <= position_i;
    end
    if (state_q == S_DECODE) begin
      dump_idx_q <= '0;
      if (is_ins && full) begin
        res_status_q <= ST_FULL;
      end else if ((is_del || is_dump) && empty) begin
        res_status_q <= ST_EMPTY;
      end else begin
        res_status_q <= ST_OK;
      end
      case (op_q)
        OP_INS_LAST: idx_q <= IDX_W'(count_q);
        OP_DEL_LAST: idx_q <= tail;
        default:     idx_q <= '0;
      endcase
    end
    if (state_q == S_MOD && rem_done) begin
      idx_q <= IDX_W'(rem);
    end
    if (state_q == S_DUMP && out_load) begin
      dump_idx_q <= dump_idx_q + IDX_W'(1);
    end
    if (out_load) begin
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_q;
    end
  end

  iidl_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (pos_q),
    .divisor_i  (count_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = words[0];
    end else begin : g_mid_p
      assign prev_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign next_w = words[g];
    end else begin : g_mid_n
      assign next_w = words[g+1];
    end
    iidl_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .slot_i (IDX_W'(g)),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (words[0]),
      .new_i  (val_q),
      .word_o (words[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign last_o      = out_last_q;
  assign status_o    = out_status_q;
  assign count_o     = OUT_CNT_W'(out_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && rem_done) |-> (rem < count_q))
    else $error("remainder not below entry count");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_mid_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK && state_q == S_DUMP))
    else $error("non-final result outside a dump");

endmodule
